[sv/b64le_pkg.sv]
// shared types, character constants and the sextet-to-ascii map
// for the line-wrapped base64 encoder; no dependencies
package b64le_pkg;

   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_PAD = 8'd61;
   localparam logic [4:0] LINE_GROUPS = 5'd19;
   localparam int MAX_CHARS = 6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_of_run;
      logic       end_of_text;
   } rsp_type;

   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [2:0]                count;
      logic                      eot;
   } burst_type;

   function automatic logic [7:0] sextet(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26) begin
         sextet = 8'd65 + w;
      end else if (v < 6'd52) begin
         sextet = 8'd71 + w;
      end else if (v < 6'd62) begin
         sextet = w - 8'd4;
      end else if (v == 6'd62) begin
         sextet = 8'd43;
      end else begin
         sextet = 8'd47;
      end
   endfunction

endpackage

[sv/b64le_core.sv]
// group collection, line counting and character burst generation
// depends on b64le_pkg
module b64le_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  b64le_pkg::req_type  req_data,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   output b64le_pkg::burst_type burst
);

   logic        wrap_ff, wrap_in;
   logic [15:0] held_ff, held_in;
   logic [1:0]  gp_ff, gp_in;
   logic [4:0]  gol_ff, gol_in;
   logic        started_ff, started_in;

   logic [1:0]  gp_eff, count;
   logic [15:0] held_new;
   logic [7:0]  b0, b1, b2, g0, g1, g2, g3;
   logic [4:0]  gol_inc;
   logic        lead, last, complete, brk, tail;

   always_comb begin
      last = req_data.end_of_buffer;
      lead = !started_ff && wrap_ff;
      gp_eff = (gp_ff == 2'd3) ? 2'd2 : gp_ff;
      count = gp_eff + 2'd1;
      case (gp_eff)
         2'd0: held_new = {req_data.data_byte, 8'h00};
         2'd1: held_new = {held_ff[15:8], req_data.data_byte};
         default: held_new = held_ff;
      endcase
      complete = (count == 2'd3) || last;
      b0 = held_new[15:8];
      b1 = (count >= 2'd2) ? held_new[7:0] : 8'h00;
      b2 = (count == 2'd3) ? req_data.data_byte : 8'h00;
      g0 = b64le_pkg::sextet(b0[7:2]);
      g1 = b64le_pkg::sextet({b0[1:0], b1[7:4]});
      g2 = (count >= 2'd2) ? b64le_pkg::sextet({b1[3:0], b2[7:6]}) : b64le_pkg::CHAR_PAD;
      g3 = (count == 2'd3) ? b64le_pkg::sextet(b2[5:0]) : b64le_pkg::CHAR_PAD;
      gol_inc = gol_ff + 5'd1;
      brk = !last && (gol_inc >= b64le_pkg::LINE_GROUPS);
      tail = last ? wrap_ff : brk;

      if (lead) begin
         burst.chars = {b64le_pkg::CHAR_LF, g3, g2, g1, g0, b64le_pkg::CHAR_LF};
      end else begin
         burst.chars = {b64le_pkg::CHAR_LF, b64le_pkg::CHAR_LF, g3, g2, g1, g0};
      end
      burst.count = {2'b00, lead} + (complete ? 3'd4 : 3'd0)
                  + ((complete && tail) ? 3'd1 : 3'd0);
      burst.eot = last;

      wrap_in = csr_wr_en ? csr_wr_data : wrap_ff;
      held_in = held_ff;
      gp_in = gp_ff;
      gol_in = gol_ff;
      started_in = started_ff;
      if (accept) begin
         started_in = !last;
         if (complete) begin
            held_in = 16'h0000;
            gp_in = 2'd0;
            gol_in = (last || brk) ? 5'd0 : gol_inc;
         end else begin
            held_in = held_new;
            gp_in = count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= 1'b0;
         held_ff <= 16'h0000;
         gp_ff <= 2'd0;
         gol_ff <= 5'd0;
         started_ff <= 1'b0;
      end else begin
         wrap_ff <= wrap_in;
         held_ff <= held_in;
         gp_ff <= gp_in;
         gol_ff <= gol_in;
         started_ff <= started_in;
      end
   end

endmodule

[sv/b64le_serializer.sv]
// burst register and one-character-per-cycle output stage, advancing while rsp_stall is low
// depends on b64le_pkg
module b64le_serializer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  b64le_pkg::burst_type burst,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output b64le_pkg::rsp_type   rsp_data
);

   logic [b64le_pkg::MAX_CHARS-1:0][7:0] chars_ff, chars_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] idx_ff, idx_in;
   logic       eot_ff, eot_in;
   logic       last, take;

   always_comb begin
      rsp_valid = (cnt_ff != 3'd0);
      last = (idx_ff == cnt_ff - 3'd1);
      take = rsp_valid && !rsp_stall;
      can_load = !rsp_valid || (take && last);
      rsp_data.out_char = chars_ff[idx_ff];
      rsp_data.last_of_run = last;
      rsp_data.end_of_text = eot_ff && last;

      chars_in = chars_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      eot_in = eot_ff;
      if (load) begin
         chars_in = burst.chars;
         cnt_in = burst.count;
         idx_in = 3'd0;
         eot_in = burst.eot;
      end else if (take) begin
         if (last) begin
            cnt_in = 3'd0;
            idx_in = 3'd0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         idx_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      eot_ff <= eot_in;
   end

`ifndef SYNTH
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff < cnt_ff))
      else $error("character index past burst length");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd6)
      else $error("burst longer than six characters");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !last) |=> (rsp_valid && idx_ff == $past(idx_ff) + 3'd1))
      else $error("burst did not advance after a taken character");

   a_eot_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.end_of_text) |-> rsp_data.last_of_run)
      else $error("end of text not on last character of item");
`endif

endmodule

[sv/base64_line_wrapped_encoder.sv]
// top level of the line-wrapped base64 encoder
// depends on b64le_pkg, b64le_core and b64le_serializer
//
//   channel  ports                                 payload
//   req      req_valid, req_stall, req_data        data_byte, end_of_buffer
//   rsp      rsp_valid, rsp_stall, rsp_data        out_char, last_of_run, end_of_text
//   csr      csr_wr_en, csr_wr_data                wrap_with_newlines
//
// each item turns combinationally into a burst of 0 to 6 characters
// the output stage sends one character per cycle while rsp_stall is low
// a new item is taken in the cycle the last character of the previous burst leaves
// synchronous reset clears group state, line count and the newline mode
// a stalled output holds its character; the input stalls until the burst drains
module base64_line_wrapped_encoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  b64le_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output b64le_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   b64le_pkg::burst_type burst;
   logic can_load, accept;

   assign req_stall = !can_load;
   assign accept = req_valid && can_load;

   b64le_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .burst       (burst)
   );

   b64le_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .burst     (burst),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
